// File: rtl/core/sbc_pkg.sv
// Shared constants and types for the sprite box collision scanner.
`default_nettype none
package sbc_pkg;

	// Default sizing
	localparam int SPRITE_COUNT_DEF = 16;
	localparam int TYPE_COUNT_DEF   = 5;

	// Field widths
	localparam int KIND_W   = 1;
	localparam int IDX_W    = 4;
	localparam int POS_W    = 12;
	localparam int WUNIT_W  = 6;
	localparam int HGT_W    = 8;
	localparam int INSET_W  = 6;
	localparam int TYPE_W   = 3;

	// Overlap arithmetic: position plus two insets or plus a size, signed
	localparam int SUM_W    = POS_W + 3;

	// Type bound registers
	localparam int BOUND_REGS = 6;
	localparam int BOUND_W    = 5;
	localparam int CFG_IDX_W  = 3;
	localparam logic [BOUND_W-1:0] BOUND_RESET [BOUND_REGS] =
		'{5'd0, 5'd1, 5'd8, 5'd14, 5'd15, 5'd16};

	// Request kinds
	localparam logic [KIND_W-1:0] KIND_WRITE = 1'b0;
	localparam logic [KIND_W-1:0] KIND_QUERY = 1'b1;

	// One sprite table entry
	typedef struct packed {
		logic signed [POS_W-1:0] x;
		logic signed [POS_W-1:0] y;
		logic [WUNIT_W-1:0]      w;
		logic [HGT_W-1:0]        h;
		logic [INSET_W-1:0]      ix;
		logic [INSET_W-1:0]      iy;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

endpackage
`default_nettype wire

// File: rtl/core/sbc_if.sv
// Channel interfaces: request, result and configuration write.
`default_nettype none
interface sbc_req_if;
	logic                                 valid;
	logic                                 ready;
	logic [sbc_pkg::KIND_W-1:0]           kind;
	logic [sbc_pkg::IDX_W-1:0]            sprite_index;
	logic signed [sbc_pkg::POS_W-1:0]     pos_x;
	logic signed [sbc_pkg::POS_W-1:0]     pos_y;
	logic [sbc_pkg::WUNIT_W-1:0]          width_units;
	logic [sbc_pkg::HGT_W-1:0]            height_px;
	logic [sbc_pkg::INSET_W-1:0]          inset_x;
	logic [sbc_pkg::INSET_W-1:0]          inset_y;
	logic                                 enable;

	modport source (output valid, kind, sprite_index, pos_x, pos_y, width_units,
		height_px, inset_x, inset_y, enable, input ready);
	modport sink (input valid, kind, sprite_index, pos_x, pos_y, width_units,
		height_px, inset_x, inset_y, enable, output ready);
endinterface

interface sbc_rsp_if;
	logic                         valid;
	logic                         ready;
	logic                         found;
	logic [sbc_pkg::IDX_W-1:0]    collider_index;
	logic [sbc_pkg::TYPE_W-1:0]   collider_type;
	logic                         last;

	modport source (output valid, found, collider_index, collider_type, last,
		input ready);
	modport sink (input valid, found, collider_index, collider_type, last,
		output ready);
endinterface

interface sbc_cfg_if;
	logic                            valid;
	logic                            ready;
	logic [sbc_pkg::CFG_IDX_W-1:0]   index;
	logic [sbc_pkg::BOUND_W-1:0]     data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// File: rtl/core/sbc_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module sbc_ram #(
	parameter int WIDTH = sbc_pkg::ENTRY_W,
	parameter int DEPTH = sbc_pkg::SPRITE_COUNT_DEF
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Read port, data holds while re is low
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule
`default_nettype wire

// File: rtl/core/sbc_touch.sv
// Inset bounding-box overlap test between the queried sprite and one candidate.
`default_nettype none
module sbc_touch (
	input  wire sbc_pkg::entry_t b_ent,
	input  wire sbc_pkg::entry_t s_ent,
	output logic                 touch
);

	localparam int SW = sbc_pkg::SUM_W;

	logic                                xge;
	logic                                yge;
	logic signed [sbc_pkg::POS_W-1:0]    xp, xq, yp, yq;
	logic [sbc_pkg::WUNIT_W-1:0]         wq;
	logic [sbc_pkg::HGT_W-1:0]           hq;
	logic signed [SW-1:0]                lhs_x, rhs_x, lhs_y, rhs_y;
	logic                                x_miss;
	logic                                y_hit;

	always_comb begin
		// Order the pair so the right-hand (higher) one is compared against the left box's right end
		xge = b_ent.x >= s_ent.x;
		yge = b_ent.y >= s_ent.y;
		xp  = xge ? b_ent.x : s_ent.x;
		xq  = xge ? s_ent.x : b_ent.x;
		wq  = xge ? s_ent.w : b_ent.w;
		yp  = yge ? b_ent.y : s_ent.y;
		yq  = yge ? s_ent.y : b_ent.y;
		hq  = yge ? s_ent.h : b_ent.h;

		// Both insets shrink the overlap; x miss and y hit per axis
		lhs_x = SW'(xp) + SW'(b_ent.ix) + SW'(s_ent.ix);
		rhs_x = SW'(xq) + SW'({wq, 2'b00});
		lhs_y = SW'(yp) + SW'(b_ent.iy) + SW'(s_ent.iy);
		rhs_y = SW'(yq) + SW'(hq);

		x_miss = lhs_x >= rhs_x;
		y_hit  = lhs_y < rhs_y;
		touch  = !x_miss && y_hit;
	end

endmodule
`default_nettype wire

// File: rtl/core/sprite_box_collision_scan_top.sv
// Sprite box collision scanner: sprite table, type bounds and scan sequencer.
//
// A write request stores one sprite entry and gives no result. A query request reads the
// named sprite, then walks the type ranges in order, reading one candidate entry per cycle,
// unless stalled, from the single read port of the sprite table and testing it in one
// overlap unit. A query holds the request channel until its final result is loaded. Each
// collider is held back one place so that the final one can carry last; a backed-up result
// channel stalls the scan. A query with no collider, or naming an index beyond the table,
// gives a single result with found low and last high.
`default_nettype none
module sprite_box_collision_scan_top #(
	parameter int SPRITE_COUNT = sbc_pkg::SPRITE_COUNT_DEF,
	parameter int TYPE_COUNT   = sbc_pkg::TYPE_COUNT_DEF
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	sbc_req_if.sink    req,
	sbc_rsp_if.source  rsp,
	sbc_cfg_if.sink    cfg
);

	localparam int ADDR_W = $clog2(SPRITE_COUNT);
	localparam int CNT_W  = $clog2(SPRITE_COUNT + 1);
	localparam int TW     = sbc_pkg::TYPE_W;

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_CAP_B = 4'b0010,
		ST_SCAN  = 4'b0100,
		ST_DONE  = 4'b1000
	} state_t;

	function automatic logic [CNT_W-1:0] clip_bound(input logic [sbc_pkg::BOUND_W-1:0] b);
		if (int'(b) > SPRITE_COUNT) begin
			return CNT_W'(SPRITE_COUNT);
		end else begin
			return CNT_W'(b);
		end
	endfunction

	state_t                          state_q;
	logic [sbc_pkg::BOUND_W-1:0]     bounds_q [sbc_pkg::BOUND_REGS];
	logic [SPRITE_COUNT-1:0]         written_q;
	logic [SPRITE_COUNT-1:0]         enabled_q;

	// Scan position
	logic [ADDR_W-1:0]               b_addr_q;
	sbc_pkg::entry_t                 b_q;
	logic [TW-1:0]                   t_q;
	logic [CNT_W-1:0]                s_q;
	logic [CNT_W-1:0]                hi_q;
	logic                            scan_done_q;

	// Candidate in flight through the table read
	logic                            vld_s2;
	logic                            ok_s2;
	logic [ADDR_W-1:0]               idx_s2;
	logic [TW-1:0]                   type_s2;

	// Held-back collider and hit count
	logic                            pend_v_q;
	logic [ADDR_W-1:0]               pend_idx_q;
	logic [TW-1:0]                   pend_type_q;
	logic [ADDR_W-1:0]               count_q;

	// Result register
	logic                            out_v_q;
	logic                            out_found_q;
	logic [sbc_pkg::IDX_W-1:0]       out_idx_q;
	logic [TW-1:0]                   out_type_q;
	logic                            out_last_q;

	logic                            req_ok;
	logic                            is_query;
	logic                            idx_ok;
	logic                            out_free;
	logic                            out_load;
	logic                            touch;
	logic                            hit_s2;
	logic                            need_push;
	logic                            stall;
	logic                            in_range;
	logic                            issue;
	logic [ADDR_W-1:0]               s_addr;
	logic [ADDR_W-1:0]               req_addr;
	logic [TW-1:0]                   nb_idx;
	logic [sbc_pkg::BOUND_W-1:0]     nb_val;
	logic                            ram_we;
	logic                            ram_re;
	logic [ADDR_W-1:0]               ram_raddr;
	logic [sbc_pkg::ENTRY_W-1:0]     ram_rdata;
	sbc_pkg::entry_t                 wr_ent;
	sbc_pkg::entry_t                 cand_ent;

	// Handshake and scan control
	always_comb begin
		req.ready = state_q == ST_IDLE;
		cfg.ready = 1'b1;
		req_ok    = req.valid && req.ready;
		is_query  = req.kind == sbc_pkg::KIND_QUERY;
		idx_ok    = int'(req.sprite_index) < SPRITE_COUNT;
		req_addr  = ADDR_W'(req.sprite_index);
		out_free  = !out_v_q || rsp.ready;

		cand_ent  = sbc_pkg::entry_t'(ram_rdata);
		hit_s2    = vld_s2 && ok_s2 && touch && (count_q < ADDR_W'(SPRITE_COUNT - 1));
		need_push = hit_s2 && pend_v_q;
		stall     = need_push && !out_free;

		// Result register loads a released collider or the final result
		out_load  = ((state_q == ST_SCAN) && need_push && !stall) ||
			((state_q == ST_DONE) && out_free);

		s_addr    = s_q[ADDR_W-1:0];
		in_range  = s_q < hi_q;
		issue     = (state_q == ST_SCAN) && !stall && !scan_done_q && in_range;

		nb_idx    = t_q + TW'(2);
		nb_val    = (nb_idx < TW'(sbc_pkg::BOUND_REGS)) ? bounds_q[nb_idx] : '0;

		ram_re    = (req_ok && is_query) || issue;
		ram_raddr = issue ? s_addr : req_addr;
		ram_we    = req_ok && !is_query && idx_ok;

		wr_ent.x  = {req.pos_x[sbc_pkg::POS_W-1:2], 2'b00};
		wr_ent.y  = req.pos_y;
		wr_ent.w  = req.width_units;
		wr_ent.h  = req.height_px;
		wr_ent.ix = req.inset_x;
		wr_ent.iy = req.inset_y;
	end

	sbc_ram #(
		.WIDTH (sbc_pkg::ENTRY_W),
		.DEPTH (SPRITE_COUNT)
	) u_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr (req_addr),
		.wdata (wr_ent),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	sbc_touch u_touch (
		.b_ent (b_q),
		.s_ent (cand_ent),
		.touch (touch)
	);

	// Type bound registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < sbc_pkg::BOUND_REGS; i++) begin
				bounds_q[i] <= sbc_pkg::BOUND_RESET[i];
			end
		end else if (cfg.valid && (cfg.index < sbc_pkg::CFG_IDX_W'(sbc_pkg::BOUND_REGS))) begin
			bounds_q[cfg.index] <= cfg.data;
		end
	end

	// Per-entry written and enable flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			written_q <= '0;
			enabled_q <= '0;
		end else if (ram_we) begin
			written_q[req_addr] <= 1'b1;
			enabled_q[req_addr] <= req.enable;
		end
	end

	// Sequencer, scan pipeline and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			b_addr_q    <= '0;
			b_q         <= '0;
			t_q         <= '0;
			s_q         <= '0;
			hi_q        <= '0;
			scan_done_q <= 1'b0;
			vld_s2      <= 1'b0;
			ok_s2       <= 1'b0;
			idx_s2      <= '0;
			type_s2     <= '0;
			pend_v_q    <= 1'b0;
			pend_idx_q  <= '0;
			pend_type_q <= '0;
			count_q     <= '0;
			out_v_q     <= 1'b0;
			out_found_q <= 1'b0;
			out_idx_q   <= '0;
			out_type_q  <= '0;
			out_last_q  <= 1'b0;
		end else begin
			// Result valid: set on load, cleared when taken
			if (out_load) begin
				out_v_q <= 1'b1;
			end else if (out_v_q && rsp.ready) begin
				out_v_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (req_ok && is_query) begin
						b_addr_q    <= req_addr;
						pend_v_q    <= 1'b0;
						count_q     <= '0;
						t_q         <= '0;
						s_q         <= clip_bound(bounds_q[0]);
						hi_q        <= clip_bound(bounds_q[1]);
						scan_done_q <= 1'b0;
						vld_s2      <= 1'b0;
						state_q     <= idx_ok ? ST_CAP_B : ST_DONE;
					end
				end

				ST_CAP_B: begin
					// Never-written entry reads as all zero
					b_q     <= written_q[b_addr_q] ? cand_ent : '0;
					state_q <= ST_SCAN;
				end

				ST_SCAN: begin
					if (!stall) begin
						// Step through the ranges
						if (!scan_done_q) begin
							if (in_range) begin
								s_q <= CNT_W'(s_q + 1'b1);
							end else if (t_q == TW'(TYPE_COUNT - 1)) begin
								scan_done_q <= 1'b1;
							end else begin
								t_q  <= t_q + 1'b1;
								s_q  <= hi_q;
								hi_q <= clip_bound(nb_val);
							end
						end

						// Candidate tag follows the table read
						vld_s2  <= issue;
						ok_s2   <= enabled_q[s_addr] && (s_addr != b_addr_q);
						idx_s2  <= s_addr;
						type_s2 <= t_q;

						// Hold the new collider, release the previous one
						if (hit_s2) begin
							pend_v_q    <= 1'b1;
							pend_idx_q  <= idx_s2;
							pend_type_q <= type_s2;
							count_q     <= count_q + 1'b1;
						end
						if (need_push) begin
							out_found_q <= 1'b1;
							out_idx_q   <= sbc_pkg::IDX_W'(pend_idx_q);
							out_type_q  <= pend_type_q;
							out_last_q  <= 1'b0;
						end
					end

					if (scan_done_q && !vld_s2) begin
						state_q <= ST_DONE;
					end
				end

				ST_DONE: begin
					// Final result, or the single none result
					if (out_free) begin
						out_found_q <= pend_v_q;
						out_idx_q   <= pend_v_q ? sbc_pkg::IDX_W'(pend_idx_q) : '0;
						out_type_q  <= pend_v_q ? pend_type_q : '0;
						out_last_q  <= 1'b1;
						pend_v_q    <= 1'b0;
						state_q     <= ST_IDLE;
					end
				end

				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Result channel
	always_comb begin
		rsp.valid          = out_v_q;
		rsp.found          = out_found_q;
		rsp.collider_index = out_idx_q;
		rsp.collider_type  = out_type_q;
		rsp.last           = out_last_q;
	end

endmodule
`default_nettype wire

// File: tb/sprite_box_collision_scan_top_tb.sv
// Self-checking testbench for the sprite box collision scanner, with its own scan predictor.
`timescale 1ns / 1ps
module sprite_box_collision_scan_top_tb;

	localparam int SPRITES        = sbc_pkg::SPRITE_COUNT_DEF;
	localparam int TYPES          = sbc_pkg::TYPE_COUNT_DEF;
	localparam int SETTLE_CYCLES  = 40;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int HOLD_CYCLES    = 400;
	localparam int CROWD_ITEMS    = SPRITES + 1;
	localparam int DIR_ROWS       = 20;
	localparam int SETS           = 7;

	typedef struct packed {
		logic [sbc_pkg::KIND_W-1:0]       kind;
		logic [sbc_pkg::IDX_W-1:0]        idx;
		logic signed [sbc_pkg::POS_W-1:0] x;
		logic signed [sbc_pkg::POS_W-1:0] y;
		logic [sbc_pkg::WUNIT_W-1:0]      w;
		logic [sbc_pkg::HGT_W-1:0]        h;
		logic [sbc_pkg::INSET_W-1:0]      ix;
		logic [sbc_pkg::INSET_W-1:0]      iy;
		logic                             en;
	} sprite_req_t;

	typedef struct packed {
		logic                       found;
		logic [sbc_pkg::IDX_W-1:0]  index;
		logic [sbc_pkg::TYPE_W-1:0] ctype;
		logic                       last;
	} hit_t;

	typedef struct packed {
		sprite_req_t rq;
		logic        pinned;
		hit_t        hit;
	} dir_row_t;

	logic clk;
	logic arst_n;

	sbc_req_if req_ch ();
	sbc_rsp_if rsp_ch ();
	sbc_cfg_if cfg_ch ();

	sprite_box_collision_scan_top i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch),
		.cfg    (cfg_ch)
	);

	// Predictor state: sprite table and type bounds
	sbc_pkg::entry_t             sprite_tbl [SPRITES];
	logic                        sprite_on  [SPRITES];
	logic [sbc_pkg::BOUND_W-1:0] bound_reg  [sbc_pkg::BOUND_REGS];
	hit_t                        expected_hits [$];

	// Directed rows may pin the expected result of a query
	logic pin_next;
	hit_t pin_hit;

	int send_idle_pct;
	int recv_idle_pct;
	logic hold_start;
	int mismatches;
	int n_writes, n_queries, n_results, widest_burst;
	int stall_cycles;

	dir_row_t directed_rows [DIR_ROWS];
	logic [sbc_pkg::BOUND_W-1:0] bound_sets [SETS][sbc_pkg::BOUND_REGS] = '{
		'{5'd0,  5'd4,  5'd8,  5'd12, 5'd14, 5'd16},
		'{5'd31, 5'd31, 5'd31, 5'd31, 5'd31, 5'd31},
		'{5'd0,  5'd16, 5'd16, 5'd16, 5'd16, 5'd16},
		'{5'd16, 5'd0,  5'd31, 5'd2,  5'd2,  5'd16},
		'{5'd0,  5'd0,  5'd0,  5'd0,  5'd0,  5'd0},
		'{5'd0,  5'd0,  5'd0,  5'd0,  5'd0,  5'd0},
		'{5'd0,  5'd1,  5'd8,  5'd14, 5'd15, 5'd16}
	};
	int set_items [SETS] = '{50, 25, 50, 50, 60, 15, 40};

	// Clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	task automatic report_mismatch(input string what, input int got, input int want);
		mismatches++;
		$display("ERROR at %0t: %s: got %0d, expected %0d", $time, what, got, want);
	endtask

	// Inset bounding-box test of queried sprite b against candidate s
	function automatic bit boxes_touch(input int b, input int s);
		int xb, xs, yb, ys, wb, ws, hb, hs, ixb, ixs, iyb, iys;
		xb  = $signed(sprite_tbl[b].x);
		xs  = $signed(sprite_tbl[s].x);
		yb  = $signed(sprite_tbl[b].y);
		ys  = $signed(sprite_tbl[s].y);
		wb  = 4 * int'(sprite_tbl[b].w);
		ws  = 4 * int'(sprite_tbl[s].w);
		hb  = int'(sprite_tbl[b].h);
		hs  = int'(sprite_tbl[s].h);
		ixb = int'(sprite_tbl[b].ix);
		ixs = int'(sprite_tbl[s].ix);
		iyb = int'(sprite_tbl[b].iy);
		iys = int'(sprite_tbl[s].iy);
		if (xb >= xs) begin
			if (xb + ixb > ws + xs - ixs - 1)
				return 1'b0;
		end else if (xs + ixs > wb + xb - ixb - 1) begin
			return 1'b0;
		end
		if (yb >= ys)
			return (yb + iyb <= hs + ys - iys - 1);
		return (ys + iys <= hb + yb - iyb - 1);
	endfunction

	// Walk type ranges in order and queue one result per collider (at most SPRITES - 1), or one none result
	function automatic void scan_colliders(input int q);
		int lo, hi, hits;
		hit_t h;
		hits = 0;
		for (int t = 0; t < TYPES; t++) begin
			lo = (bound_reg[t] > SPRITES) ? SPRITES : int'(bound_reg[t]);
			hi = (bound_reg[t + 1] > SPRITES) ? SPRITES : int'(bound_reg[t + 1]);
			for (int s = lo; s < hi; s++) begin
				if (sprite_on[s] && s != q && boxes_touch(q, s) && hits < SPRITES - 1) begin
					h.found = 1'b1;
					h.index = sbc_pkg::IDX_W'(s);
					h.ctype = sbc_pkg::TYPE_W'(t);
					h.last  = 1'b0;
					expected_hits.push_back(h);
					hits++;
				end
			end
		end
		if (hits == 0) begin
			h = '0;
			h.last = 1'b1;
			expected_hits.push_back(h);
		end else begin
			h = expected_hits.pop_back();
			h.last = 1'b1;
			expected_hits.push_back(h);
		end
		if (hits > widest_burst)
			widest_burst = hits;
	endfunction

	// Monitor: check results, update predictor on accepted requests and register writes
	always @(posedge clk) begin
		hit_t want;
		if (arst_n) begin
			if (rsp_ch.valid && rsp_ch.ready) begin
				n_results++;
				if (expected_hits.size() == 0) begin
					report_mismatch("unexpected result, index", rsp_ch.collider_index, -1);
				end else begin
					want = expected_hits.pop_front();
					if (rsp_ch.found !== want.found)
						report_mismatch("found", rsp_ch.found, want.found);
					if (rsp_ch.collider_index !== want.index)
						report_mismatch("collider_index", rsp_ch.collider_index, want.index);
					if (rsp_ch.collider_type !== want.ctype)
						report_mismatch("collider_type", rsp_ch.collider_type, want.ctype);
					if (rsp_ch.last !== want.last)
						report_mismatch("last", rsp_ch.last, want.last);
				end
			end
			if (req_ch.valid && req_ch.ready) begin
				if (req_ch.kind == sbc_pkg::KIND_WRITE) begin
					n_writes++;
					sprite_tbl[req_ch.sprite_index].x  =
						{req_ch.pos_x[sbc_pkg::POS_W-1:2], 2'b00};
					sprite_tbl[req_ch.sprite_index].y  = req_ch.pos_y;
					sprite_tbl[req_ch.sprite_index].w  = req_ch.width_units;
					sprite_tbl[req_ch.sprite_index].h  = req_ch.height_px;
					sprite_tbl[req_ch.sprite_index].ix = req_ch.inset_x;
					sprite_tbl[req_ch.sprite_index].iy = req_ch.inset_y;
					sprite_on[req_ch.sprite_index]     = req_ch.enable;
				end else begin
					n_queries++;
					if (pin_next) begin
						expected_hits.push_back(pin_hit);
						pin_next = 1'b0;
					end else begin
						scan_colliders(int'(req_ch.sprite_index));
					end
				end
			end
			if (cfg_ch.valid && cfg_ch.ready && cfg_ch.index < sbc_pkg::BOUND_REGS)
				bound_reg[cfg_ch.index] = cfg_ch.data;
		end
	end

	// Watchdog on cycles with no handshake on any channel
	always @(posedge clk) begin
		if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
			(cfg_ch.valid && cfg_ch.ready))
			stall_cycles = 0;
		else
			stall_cycles++;
		if (stall_cycles >= WATCHDOG_LIMIT) begin
			$display("no handshake for %0d cycles, %0d results pending", stall_cycles,
				expected_hits.size());
			$display("sprite_box_collision_scan_top: mismatch");
			$finish;
		end
	end

	// Result side: random stalls, plus one long hold-off when asked
	initial begin
		int hold_left;
		hold_left = 0;
		rsp_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_start) begin
				hold_left  = HOLD_CYCLES;
				hold_start = 1'b0;
			end
			if (hold_left > 0) begin
				rsp_ch.ready = 1'b0;
				hold_left--;
			end else begin
				rsp_ch.ready = ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	function automatic dir_row_t wr(input int idx, input int x, input int y, input int w,
		input int h, input int ix, input int iy, input bit en);
		dir_row_t r;
		r = '0;
		r.rq.kind = sbc_pkg::KIND_WRITE;
		r.rq.idx  = sbc_pkg::IDX_W'(idx);
		r.rq.x    = sbc_pkg::POS_W'(x);
		r.rq.y    = sbc_pkg::POS_W'(y);
		r.rq.w    = sbc_pkg::WUNIT_W'(w);
		r.rq.h    = sbc_pkg::HGT_W'(h);
		r.rq.ix   = sbc_pkg::INSET_W'(ix);
		r.rq.iy   = sbc_pkg::INSET_W'(iy);
		r.rq.en   = en;
		return r;
	endfunction

	function automatic dir_row_t qy(input int idx);
		dir_row_t r;
		r = '0;
		r.rq.kind = sbc_pkg::KIND_QUERY;
		r.rq.idx  = sbc_pkg::IDX_W'(idx);
		return r;
	endfunction

	// Query whose single result is typed in
	function automatic dir_row_t qp(input int idx, input bit f, input int ci, input int ct);
		dir_row_t r;
		r = qy(idx);
		r.pinned    = 1'b1;
		r.hit.found = f;
		r.hit.index = sbc_pkg::IDX_W'(ci);
		r.hit.ctype = sbc_pkg::TYPE_W'(ct);
		r.hit.last  = 1'b1;
		return r;
	endfunction

	function automatic sprite_req_t rand_request(input int cx, input int cy);
		sprite_req_t r;
		bit wide;
		wide   = ($urandom_range(9) == 0);
		r.kind = ($urandom_range(99) < 40) ? sbc_pkg::KIND_QUERY : sbc_pkg::KIND_WRITE;
		r.idx  = sbc_pkg::IDX_W'($urandom_range(SPRITES - 1));
		r.x    = wide ? sbc_pkg::POS_W'($urandom) :
			sbc_pkg::POS_W'(cx + int'($urandom_range(80)) - 40);
		r.y    = wide ? sbc_pkg::POS_W'($urandom) :
			sbc_pkg::POS_W'(cy + int'($urandom_range(80)) - 40);
		r.w    = wide ? sbc_pkg::WUNIT_W'($urandom) : sbc_pkg::WUNIT_W'($urandom_range(12));
		r.h    = wide ? sbc_pkg::HGT_W'($urandom) : sbc_pkg::HGT_W'($urandom_range(40));
		r.ix   = wide ? sbc_pkg::INSET_W'($urandom) : sbc_pkg::INSET_W'($urandom_range(3));
		r.iy   = wide ? sbc_pkg::INSET_W'($urandom) : sbc_pkg::INSET_W'($urandom_range(3));
		r.en   = ($urandom_range(9) != 0);
		return r;
	endfunction

	// Offer one request; called and returns at a falling edge
	task automatic send_request(input sprite_req_t r);
		while ($urandom_range(99) < send_idle_pct) begin
			req_ch.valid = 1'b0;
			@(negedge clk);
		end
		req_ch.valid        = 1'b1;
		req_ch.kind         = r.kind;
		req_ch.sprite_index = r.idx;
		req_ch.pos_x        = r.x;
		req_ch.pos_y        = r.y;
		req_ch.width_units  = r.w;
		req_ch.height_px    = r.h;
		req_ch.inset_x      = r.ix;
		req_ch.inset_y      = r.iy;
		req_ch.enable       = r.en;
		@(posedge clk);
		while (!req_ch.ready)
			@(posedge clk);
		@(negedge clk);
	endtask

	// Pile every sprite onto one spot, then query one of them
	task automatic send_crowd(input int cx, input int cy);
		sprite_req_t r;
		for (int i = 0; i < SPRITES; i++) begin
			r.kind = sbc_pkg::KIND_WRITE;
			r.idx  = sbc_pkg::IDX_W'(i);
			r.x    = sbc_pkg::POS_W'(cx + int'($urandom_range(16)) - 8);
			r.y    = sbc_pkg::POS_W'(cy + int'($urandom_range(16)) - 8);
			r.w    = sbc_pkg::WUNIT_W'($urandom_range(10, 4));
			r.h    = sbc_pkg::HGT_W'($urandom_range(48, 16));
			r.ix   = sbc_pkg::INSET_W'($urandom_range(2));
			r.iy   = sbc_pkg::INSET_W'($urandom_range(2));
			r.en   = ($urandom_range(15) != 0);
			send_request(r);
		end
		r      = rand_request(cx, cy);
		r.kind = sbc_pkg::KIND_QUERY;
		send_request(r);
	endtask

	task automatic write_bound(input int idx, input int val);
		cfg_ch.valid = 1'b1;
		cfg_ch.index = sbc_pkg::CFG_IDX_W'(idx);
		cfg_ch.data  = sbc_pkg::BOUND_W'(val);
		@(posedge clk);
		while (!cfg_ch.ready)
			@(posedge clk);
		@(negedge clk);
		cfg_ch.valid = 1'b0;
	endtask

	// Drain all results, then let trailing sprite writes finish
	task automatic wait_idle();
		req_ch.valid = 1'b0;
		while (expected_hits.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// Main sequence
	initial begin
		int cx, cy, left;
		arst_n              = 1'b0;
		req_ch.valid        = 1'b0;
		req_ch.kind         = sbc_pkg::KIND_WRITE;
		req_ch.sprite_index = '0;
		req_ch.pos_x        = '0;
		req_ch.pos_y        = '0;
		req_ch.width_units  = '0;
		req_ch.height_px    = '0;
		req_ch.inset_x      = '0;
		req_ch.inset_y      = '0;
		req_ch.enable       = 1'b0;
		cfg_ch.valid        = 1'b0;
		cfg_ch.index        = '0;
		cfg_ch.data         = '0;
		pin_next            = 1'b0;
		pin_hit             = '0;
		hold_start          = 1'b0;
		mismatches          = 0;
		n_writes            = 0;
		n_queries           = 0;
		n_results           = 0;
		widest_burst        = 0;
		stall_cycles        = 0;
		send_idle_pct       = 19;
		recv_idle_pct       = 87;
		for (int i = 0; i < SPRITES; i++) begin
			sprite_tbl[i] = '0;
			sprite_on[i]  = 1'b0;
		end
		for (int i = 0; i < sbc_pkg::BOUND_REGS; i++)
			bound_reg[i] = sbc_pkg::BOUND_RESET[i];

		// Directed rows: empty table, simple hits, extremes, disabled and zero-size sprites
		directed_rows = '{
			qp(0, 1'b0, 0, 0),
			qp(15, 1'b0, 0, 0),
			wr(0, 0, 0, 4, 16, 0, 0, 1'b1),
			wr(1, 3, 8, 2, 8, 0, 0, 1'b1),
			qp(0, 1'b1, 1, 1),
			qp(1, 1'b1, 0, 0),
			wr(15, -2048, -2048, 63, 255, 63, 63, 1'b1),
			wr(14, 2047, 2047, 63, 255, 0, 0, 1'b1),
			qy(15),
			qy(14),
			wr(5, 4, 4, 1, 1, 0, 0, 1'b0),
			qy(5),
			wr(7, -4, -4, 0, 0, 0, 0, 1'b1),
			qy(7),
			wr(8, 0, 0, 63, 255, 63, 63, 1'b1),
			qy(8),
			wr(2, 12, 0, 1, 1, 0, 0, 1'b1),
			qy(0),
			wr(0, -2048, 2047, 0, 0, 63, 63, 1'b0),
			qy(3)
		};

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		for (int i = 0; i < DIR_ROWS; i++) begin
			pin_next = directed_rows[i].pinned;
			pin_hit  = directed_rows[i].hit;
			send_request(directed_rows[i].rq);
		end

		// Random phases, one bound setting each
		for (int s = 0; s < SETS; s++) begin
			wait_idle();
			send_idle_pct = (s < 2) ? 19 : (s < 4) ? 87 : 0;
			recv_idle_pct = (s < 2) ? 87 : (s < 4) ? 19 : 0;
			for (int k = 0; k < sbc_pkg::BOUND_REGS; k++)
				write_bound(k, (s == 4) ? int'($urandom_range(31)) : int'(bound_sets[s][k]));
			// unused register indexes
			if (s == 1) begin
				write_bound(sbc_pkg::BOUND_REGS, $urandom_range(31));
				write_bound(sbc_pkg::BOUND_REGS + 1, $urandom_range(31));
			end
			if (s == 4)
				hold_start = 1'b1;
			cx   = int'($urandom_range(2000)) - 1000;
			cy   = int'($urandom_range(2000)) - 1000;
			left = set_items[s];
			while (left > 0) begin
				if (left >= CROWD_ITEMS && $urandom_range(4) == 0) begin
					send_crowd(cx, cy);
					left -= CROWD_ITEMS;
				end else begin
					send_request(rand_request(cx, cy));
					left--;
				end
			end
		end
		wait_idle();

		$display("covered %0d sprite writes, %0d queries, %0d results, up to %0d per query",
			n_writes, n_queries, n_results, widest_burst);
		$display("bounds from empty to whole-table, three stall patterns, one long hold");
		if (mismatches == 0)
			$display("sprite_box_collision_scan_top: match");
		else
			$display("sprite_box_collision_scan_top: mismatch");
		$finish;
	end

endmodule

// File: files.f
rtl/core/sbc_pkg.sv
rtl/core/sbc_if.sv
rtl/core/sbc_ram.sv
rtl/core/sbc_touch.sv
rtl/core/sprite_box_collision_scan_top.sv
tb/sprite_box_collision_scan_top_tb.sv
